>>> design/pwmc_pkg.sv
// Shared types, widths and constants for the PWM period and duty capture block.
`default_nettype none
package pwmc_pkg;

  localparam int CNT_W      = 16;                 // capture timer width
  localparam int TB_W       = 27;                 // timebase register width
  localparam int FREQ_W     = TB_W + 8;           // Q.8 frequency width
  localparam int DUTY_W     = 15;                 // Q.8 percent width
  localparam int DUTY_NUM_W = CNT_W + DUTY_W;     // high_ticks * 25600
  localparam int DIV_STEPS  = FREQ_W;             // one quotient bit per step
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  localparam logic [TB_W-1:0]       TB_RESET   = TB_W'(1000000);
  localparam logic [DUTY_NUM_W-1:0] DUTY_SCALE = DUTY_NUM_W'(25600);

  // Edge phase codes.
  localparam logic [1:0] PH_FIRST_RISE = 2'd0;
  localparam logic [1:0] PH_FALL       = 2'd1;
  localparam logic [1:0] PH_CLOSE_RISE = 2'd2;

  // Queue geometry.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // One classified edge, handed from the front end to the divider.
  typedef struct packed {
    logic                  next_edge_falling;
    logic                  meas_valid;
    logic [CNT_W-1:0]      period;
    logic [CNT_W-1:0]      high;
    logic [DUTY_NUM_W-1:0] duty_num;
  } pwmc_cmd_t;

endpackage
`default_nettype wire

>>> design/pwmc_front.sv
// Front end: tracks the edge phase, forms period and high time, checks them.
`default_nettype none
module pwmc_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [pwmc_pkg::CNT_W-1:0]   in_capture_stamp,
  input  wire logic                         q_full,
  output logic                              q_push,
  output pwmc_pkg::pwmc_cmd_t               q_cmd
);

  logic [1:0]                 phase_r, phase_nxt;
  logic [pwmc_pkg::CNT_W-1:0] rise_r, rise_nxt;
  logic [pwmc_pkg::CNT_W-1:0] fall_r, fall_nxt;
  logic [pwmc_pkg::CNT_W-1:0] period;
  logic [pwmc_pkg::CNT_W-1:0] high;
  logic                       ok;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Differences wrap modulo the counter width.
  assign period = in_capture_stamp - rise_r;
  assign high   = fall_r - rise_r;
  assign ok     = (period != '0) && (high <= period);

  always_comb begin
    phase_nxt = phase_r;
    rise_nxt  = rise_r;
    fall_nxt  = fall_r;
    q_cmd     = '0;
    unique case (phase_r)
      pwmc_pkg::PH_FIRST_RISE: begin
        rise_nxt                = in_capture_stamp;
        phase_nxt               = pwmc_pkg::PH_FALL;
        q_cmd.next_edge_falling = 1'b1;
      end
      pwmc_pkg::PH_FALL: begin
        fall_nxt  = in_capture_stamp;
        phase_nxt = pwmc_pkg::PH_CLOSE_RISE;
      end
      default: begin
        // Closing rising edge; the unused phase code behaves the same way.
        phase_nxt        = pwmc_pkg::PH_FIRST_RISE;
        q_cmd.meas_valid = ok;
        if (ok) begin
          q_cmd.period   = period;
          q_cmd.high     = high;
          q_cmd.duty_num = pwmc_pkg::DUTY_NUM_W'(high) * pwmc_pkg::DUTY_SCALE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pwmc_pkg::PH_FIRST_RISE;
      rise_r  <= '0;
      fall_r  <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/pwmc_queue.sv
// Two-entry queue between the edge front end and the divider back end.
`default_nettype none
module pwmc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire pwmc_pkg::pwmc_cmd_t  push_cmd,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      not_empty,
  output pwmc_pkg::pwmc_cmd_t       head_cmd
);

  pwmc_pkg::pwmc_cmd_t               mem_r [pwmc_pkg::Q_DEPTH];
  logic [pwmc_pkg::Q_PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [pwmc_pkg::Q_CNT_W-1:0]      count_r, count_nxt;

  assign full      = (count_r == pwmc_pkg::Q_CNT_W'(pwmc_pkg::Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pwmc_pkg::Q_CNT_W'(pwmc_pkg::Q_DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

>>> design/pwmc_back.sv
// Back end: two bit-serial restoring dividers and the output word register.
`default_nettype none
module pwmc_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [pwmc_pkg::TB_W-1:0]      timebase,
  input  wire logic                           q_not_empty,
  input  wire pwmc_pkg::pwmc_cmd_t            q_cmd,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_next_edge_falling,
  output logic                                out_measurement_valid,
  output logic [pwmc_pkg::CNT_W-1:0]          out_period_ticks,
  output logic [pwmc_pkg::CNT_W-1:0]          out_high_ticks,
  output logic [pwmc_pkg::FREQ_W-1:0]         out_frequency_q8,
  output logic [pwmc_pkg::DUTY_W-1:0]         out_duty_percent_q8
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  pwmc_pkg::pwmc_cmd_t           cmd_r;
  logic [pwmc_pkg::FREQ_W-1:0]   fq_r;    // frequency dividend in, quotient out
  logic [pwmc_pkg::FREQ_W-1:0]   dq_r;    // duty dividend in, quotient out
  logic [pwmc_pkg::CNT_W-1:0]    frem_r, drem_r;
  logic [pwmc_pkg::STEP_W-1:0]   step_r;
  logic                          out_valid_r;
  logic                          out_free;

  logic [pwmc_pkg::CNT_W:0]      frs, drs;
  logic                          fge, dge;

  // One restoring step per cycle: shift in the next dividend bit and try
  // to subtract the period.
  assign frs = {frem_r, fq_r[pwmc_pkg::FREQ_W-1]};
  assign drs = {drem_r, dq_r[pwmc_pkg::FREQ_W-1]};
  assign fge = frs >= {1'b0, cmd_r.period};
  assign dge = drs >= {1'b0, cmd_r.period};

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign q_pop     = (state_r == ST_IDLE) && q_not_empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          state_nxt = q_cmd.meas_valid ? ST_DIV : ST_HOLD;
        end
      end
      ST_DIV: begin
        if (step_r == pwmc_pkg::STEP_W'(pwmc_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ((state_r == ST_HOLD) && out_free) || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r  <= q_cmd;
      fq_r   <= {timebase, 8'b0};
      dq_r   <= pwmc_pkg::FREQ_W'(q_cmd.duty_num);
      frem_r <= '0;
      drem_r <= '0;
      step_r <= '0;
    end else if (state_r == ST_DIV) begin
      fq_r   <= {fq_r[pwmc_pkg::FREQ_W-2:0], fge};
      dq_r   <= {dq_r[pwmc_pkg::FREQ_W-2:0], dge};
      frem_r <= fge ? pwmc_pkg::CNT_W'(frs - {1'b0, cmd_r.period})
                    : frs[pwmc_pkg::CNT_W-1:0];
      drem_r <= dge ? pwmc_pkg::CNT_W'(drs - {1'b0, cmd_r.period})
                    : drs[pwmc_pkg::CNT_W-1:0];
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_HOLD) && out_free) begin
      out_next_edge_falling <= cmd_r.next_edge_falling;
      out_measurement_valid <= cmd_r.meas_valid;
      out_period_ticks      <= cmd_r.period;
      out_high_ticks        <= cmd_r.high;
      out_frequency_q8      <= cmd_r.meas_valid ? fq_r : '0;
      out_duty_percent_q8   <= cmd_r.meas_valid ? dq_r[pwmc_pkg::DUTY_W-1:0] : '0;
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (step_r < pwmc_pkg::STEP_W'(pwmc_pkg::DIV_STEPS)))
    else $error("divider step count overran");

  a_valid_period: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_measurement_valid) |->
      (out_period_ticks != '0) && (out_high_ticks <= out_period_ticks))
    else $error("valid measurement with bad period or high time");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_measurement_valid) |->
      (out_frequency_q8 == '0) && (out_duty_percent_q8 == '0))
    else $error("invalid measurement carries nonzero results");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_DIV) || (state_r == ST_HOLD))
    else $error("popped word did not start processing");

endmodule
`default_nettype wire

>>> design/pwm_period_duty_capture.sv
// Top level of the PWM period and duty capture block.
// A word with a valid measurement passes through the queue, 35 divider steps, the hold state
// and the output register after it is accepted; other words skip the divider.
// Throughput is set by the bit-serial dividers: the back end works on one word at a time;
// a full rise, fall, rise sequence keeps the back end busy, and a two-word queue
// lets further edge words be accepted meanwhile, until the queue is full.
// Reset (rst_n, synchronous, active low) clears phase, queue and output valid, timebase 1000000.
`default_nettype none
module pwm_period_duty_capture (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Configuration: timebase tick rate in Hz.
  input  wire logic                           cfg_we,
  input  wire logic [pwmc_pkg::TB_W-1:0]      cfg_wdata,
  // Input channel: one capture stamp per word.
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [pwmc_pkg::CNT_W-1:0]     in_capture_stamp,
  // Result channel: one result word per input word.
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_next_edge_falling,
  output logic                                out_measurement_valid,
  output logic [pwmc_pkg::CNT_W-1:0]          out_period_ticks,
  output logic [pwmc_pkg::CNT_W-1:0]          out_high_ticks,
  output logic [pwmc_pkg::FREQ_W-1:0]         out_frequency_q8,
  output logic [pwmc_pkg::DUTY_W-1:0]         out_duty_percent_q8
);

  // The timebase register must be written by the user only while the block is idle, which
  // the block does not enforce; so the back end may sample it directly when it starts a division.
  logic [pwmc_pkg::TB_W-1:0] timebase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timebase_r <= pwmc_pkg::TB_RESET;
    end else if (cfg_we) begin
      timebase_r <= cfg_wdata;
    end
  end

  // The front end classifies each stamp by edge phase and, on the closing
  // rising edge, forms the wrapped period and high time and checks them.
  // It also precomputes high time times 25600 so that the back end only
  // has to divide.
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_not_empty;
  pwmc_pkg::pwmc_cmd_t push_cmd;
  pwmc_pkg::pwmc_cmd_t head_cmd;

  pwmc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_capture_stamp (in_capture_stamp),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (push_cmd)
  );

  // A short queue decouples the edge stream from the slow divider.
  pwmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // The back end runs the frequency and duty divisions side by side, one
  // quotient bit per cycle each, then parks the word in the output register.
  // Words that carry no measurement skip the divider.
  pwmc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .timebase              (timebase_r),
    .q_not_empty           (q_not_empty),
    .q_cmd                 (head_cmd),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_next_edge_falling (out_next_edge_falling),
    .out_measurement_valid (out_measurement_valid),
    .out_period_ticks      (out_period_ticks),
    .out_high_ticks        (out_high_ticks),
    .out_frequency_q8      (out_frequency_q8),
    .out_duty_percent_q8   (out_duty_percent_q8)
  );

endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the PWM period and duty capture block.
`timescale 1ns / 1ps
module tb;

  localparam int HALF_PERIOD  = 5;
  // A stretch this long with no word moving on either side means the block hung.
  localparam int IDLE_LIMIT   = 4000;
  // Settling time after the last result, a little above the divider latency.
  localparam int DRAIN_CYCLES = 50;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [pwmc_pkg::TB_W-1:0] TB_MAX_HZ   = pwmc_pkg::TB_W'(72000000);
  localparam logic [pwmc_pkg::TB_W-1:0] TB_ALL_ONES = '1;

  // Edge phase as tracked by the predictor.
  typedef enum logic [1:0] {
    EDGE_FIRST_RISE = pwmc_pkg::PH_FIRST_RISE,
    EDGE_FALL       = pwmc_pkg::PH_FALL,
    EDGE_CLOSE_RISE = pwmc_pkg::PH_CLOSE_RISE
  } edge_phase_t;

  // One result word as the block should deliver it.
  typedef struct packed {
    logic                            next_edge_falling;
    logic                            measurement_valid;
    logic [pwmc_pkg::CNT_W-1:0]      period_ticks;
    logic [pwmc_pkg::CNT_W-1:0]      high_ticks;
    logic [pwmc_pkg::FREQ_W-1:0]     frequency_q8;
    logic [pwmc_pkg::DUTY_W-1:0]     duty_percent_q8;
  } capture_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [pwmc_pkg::TB_W-1:0]   cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [pwmc_pkg::CNT_W-1:0]  in_capture_stamp = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_next_edge_falling;
  logic                        out_measurement_valid;
  logic [pwmc_pkg::CNT_W-1:0]  out_period_ticks;
  logic [pwmc_pkg::CNT_W-1:0]  out_high_ticks;
  logic [pwmc_pkg::FREQ_W-1:0] out_frequency_q8;
  logic [pwmc_pkg::DUTY_W-1:0] out_duty_percent_q8;

  // Predictor state: the edge phase, the two stored stamps and the timebase.
  edge_phase_t                cur_phase = EDGE_FIRST_RISE;
  logic [pwmc_pkg::CNT_W-1:0] open_rise = '0;
  logic [pwmc_pkg::CNT_W-1:0] open_fall = '0;
  logic [pwmc_pkg::TB_W-1:0]  tick_rate_hz = pwmc_pkg::TB_RESET;

  // Results the block still owes us, oldest first.
  capture_result_t capture_results_due[$];
  capture_result_t want_result;

  // Percent of cycles in which the sender idles and the receiver stalls.
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  // A request for a long receiver hold-off; the receiver process counts it down.
  int hold_request = 0;
  int hold_left = 0;

  int err_count = 0;
  int stamps_sent = 0;
  int results_checked = 0;
  int good_measurements = 0;
  int rejected_closes = 0;
  int timebase_writes = 0;
  int input_stall_cycles = 0;
  int quiet_cycles = 0;

  pwm_period_duty_capture dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_capture_stamp     (in_capture_stamp),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_next_edge_falling(out_next_edge_falling),
    .out_measurement_valid(out_measurement_valid),
    .out_period_ticks     (out_period_ticks),
    .out_high_ticks       (out_high_ticks),
    .out_frequency_q8     (out_frequency_q8),
    .out_duty_percent_q8  (out_duty_percent_q8)
  );

  always #HALF_PERIOD clk = ~clk;

  // Advances the edge phase for one accepted stamp and queues the result word
  // it must produce. Only the closing rising edge carries a measurement, and
  // only when the period is nonzero and the high time fits inside it.
  task automatic predict_capture(input logic [pwmc_pkg::CNT_W-1:0] stamp);
    capture_result_t            res;
    logic [pwmc_pkg::CNT_W-1:0] prd;
    logic [pwmc_pkg::CNT_W-1:0] hi;
    res = '0;
    unique case (cur_phase)
      EDGE_FIRST_RISE: begin
        open_rise = stamp;
        cur_phase = EDGE_FALL;
        res.next_edge_falling = 1'b1;
      end
      EDGE_FALL: begin
        open_fall = stamp;
        cur_phase = EDGE_CLOSE_RISE;
      end
      default: begin
        // Both differences wrap around the 16-bit timer.
        prd = stamp - open_rise;
        hi = open_fall - open_rise;
        cur_phase = EDGE_FIRST_RISE;
        if (prd != '0 && hi <= prd) begin
          res.measurement_valid = 1'b1;
          res.period_ticks = prd;
          res.high_ticks = hi;
          res.frequency_q8 = {tick_rate_hz, 8'd0} / pwmc_pkg::FREQ_W'(prd);
          res.duty_percent_q8 = pwmc_pkg::DUTY_W'(
            (pwmc_pkg::DUTY_NUM_W'(hi) * pwmc_pkg::DUTY_SCALE) /
            pwmc_pkg::DUTY_NUM_W'(prd));
          good_measurements++;
        end else begin
          rejected_closes++;
        end
      end
    endcase
    capture_results_due.push_back(res);
  endtask

  // Offers one stamp word, with random idle cycles ahead of it, and returns
  // just after the rising edge that accepted it. Valid stays high until the
  // next falling edge, where the next call or release_input decides.
  task automatic send_stamp(input logic [pwmc_pkg::CNT_W-1:0] stamp);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_capture_stamp = stamp;
    do @(posedge clk); while (in_stall);
    stamps_sent++;
    predict_capture(stamp);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Stops offering words and waits for every outstanding result.
  task automatic drain_results();
    release_input();
    while (capture_results_due.size() != 0) @(posedge clk);
  endtask

  // Timebase writes only happen with the block idle.
  task automatic write_timebase(input logic [pwmc_pkg::TB_W-1:0] hz);
    drain_results();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = hz;
    @(negedge clk);
    cfg_we = 1'b0;
    tick_rate_hz = hz;
    timebase_writes++;
  endtask

  task automatic send_edges(input logic [pwmc_pkg::CNT_W-1:0] rise, fall, close);
    send_stamp(rise);
    send_stamp(fall);
    send_stamp(close);
  endtask

  // One PWM period with random content. Most are well formed; some have a
  // zero period or a high time past the period, and a few carry a stray edge
  // in front that knocks the phase out of step with the sequence.
  task automatic send_pwm_period();
    logic [pwmc_pkg::CNT_W-1:0] rise;
    logic [pwmc_pkg::CNT_W-1:0] prd;
    logic [pwmc_pkg::CNT_W-1:0] hi;
    int                         kind;
    // Realign to a first rising edge after any stray edge.
    while (cur_phase != EDGE_FIRST_RISE) send_stamp(pwmc_pkg::CNT_W'($urandom));
    kind = $urandom_range(99);
    rise = pwmc_pkg::CNT_W'($urandom);
    prd = pwmc_pkg::CNT_W'($urandom_range(65535, 1));
    hi = pwmc_pkg::CNT_W'($urandom_range(prd, 0));
    if (kind < 6) begin
      prd = '0;
    end else if (kind < 14 && prd != '1) begin
      hi = pwmc_pkg::CNT_W'($urandom_range(65535, prd + 1));
    end else if (kind < 22) begin
      prd = pwmc_pkg::CNT_W'($urandom_range(4, 1));
      hi = pwmc_pkg::CNT_W'($urandom_range(prd, 0));
    end else if (kind < 28) begin
      prd = '1;
    end else if (kind < 32) begin
      hi = prd;
    end
    if (kind >= 95) send_stamp(pwmc_pkg::CNT_W'($urandom));
    send_edges(rise, rise + hi, rise + prd);
  endtask

  // Corner shapes at the reset timebase: shortest period with no high time,
  // a sequence that wraps the timer, full duty, zero period and a high time
  // longer than the period.
  task automatic test_edge_cases();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    send_edges(16'h0000, 16'h0000, 16'h0001);
    send_edges(16'hFFF0, 16'h0010, 16'h0020);
    send_edges(16'd100, 16'd200, 16'd200);
    send_edges(16'd5, 16'd6, 16'd5);
    send_edges(16'd10, 16'd50, 16'd30);
  endtask

  // Timebase at its limits, each paired with a period that stresses the
  // frequency division: the largest quotient and one that floors to zero.
  task automatic test_timebase_extremes();
    write_timebase(pwmc_pkg::TB_W'(1));
    send_edges(16'h0000, 16'h8000, 16'hFFFF);
    write_timebase(TB_ALL_ONES);
    send_edges(16'h1234, 16'h1235, 16'h1235);
    write_timebase(TB_MAX_HZ);
    send_edges(16'hFFFE, 16'h0001, 16'h0005);
    write_timebase('0);
    send_edges(16'h0100, 16'h0101, 16'h0103);
    write_timebase(pwmc_pkg::TB_RESET);
  endtask

  task automatic test_random_traffic(input int periods, input int src_pct,
                                     input int snk_pct,
                                     input logic [pwmc_pkg::TB_W-1:0] hz);
    write_timebase(hz);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    repeat (periods) send_pwm_period();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering words, so the queue and output register fill and the block
  // stalls its input.
  task automatic test_output_backpressure();
    drain_results();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_request = HOLD_CYCLES;
    repeat (24) send_pwm_period();
  endtask

  // The sender stops between bursts until every result is back, so the
  // block restarts from an empty pipeline each time.
  task automatic test_sender_pause();
    src_idle_pct = 10;
    snk_stall_pct = 30;
    repeat (4) begin
      repeat (6) send_pwm_period();
      drain_results();
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < snk_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // Every accepted result word is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (capture_results_due.size() == 0) begin
        $error("result word arrived with no result expected");
        err_count++;
      end else begin
        want_result = capture_results_due.pop_front();
        check_field("next_edge_falling", want_result.next_edge_falling,
                    out_next_edge_falling);
        check_field("measurement_valid", want_result.measurement_valid,
                    out_measurement_valid);
        check_field("period_ticks", want_result.period_ticks, out_period_ticks);
        check_field("high_ticks", want_result.high_ticks, out_high_ticks);
        check_field("frequency_q8", want_result.frequency_q8, out_frequency_q8);
        check_field("duty_percent_q8", want_result.duty_percent_q8,
                    out_duty_percent_q8);
        results_checked++;
      end
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall) input_stall_cycles++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_edge_cases();
    test_timebase_extremes();
    // Sender busy and receiver mostly stalled, then the reverse, then
    // both running flat out, each with its own timebase.
    test_random_traffic(220, 15, 88, pwmc_pkg::TB_RESET);
    test_random_traffic(220, 88, 15, pwmc_pkg::TB_W'($urandom_range(72000000, 1)));
    test_random_traffic(220, 0, 0, TB_MAX_HZ);
    test_output_backpressure();
    test_sender_pause();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d result words from %0d stamps: %0d measurements, %0d rejected.",
             results_checked, stamps_sent, good_measurements, rejected_closes);
    $display("Timebase written %0d times; input stalled with a word waiting in %0d cycles.",
             timebase_writes, input_stall_cycles);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
design/pwmc_pkg.sv
design/pwmc_front.sv
design/pwmc_queue.sv
design/pwmc_back.sv
design/pwm_period_duty_capture.sv
dv/tb.sv
